FILE: src/rhc_pkg.sv
// ---------------------------------------------------------------------------
// rhc_pkg
// Fixed-point constants and operation codes for the RGB/HSV colour converter.
// ---------------------------------------------------------------------------
package rhc_pkg;

   localparam int CH_W   = 8;
   localparam int HUE_W  = 15;
   localparam int FACT_W = 12;
   localparam int FUNC_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_RGB2HSV = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_HSV2RGB = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SAT_ADJ = 2'd2;

   localparam int CHAN_MAX = 255;
   localparam int HUE_SEXT = 3840;
   localparam int HUE_FULL = 23040;
   localparam int HSV_DEN  = 979200;

endpackage

FILE: src/rhc_div.sv
// ---------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, several lanes, two quotient bits per stage (one in the last stage when QW is odd).
// ---------------------------------------------------------------------------
module rhc_div #(
   parameter int LANES = 2,
   parameter int NW    = 24,
   parameter int DW    = 9,
   parameter int QW    = 15,
   parameter int SW    = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [LANES-1:0][NW-1:0]     in_num,
   input  logic [LANES-1:0][DW-1:0]     in_den,
   input  logic [SW-1:0]                in_side,
   output logic                         out_valid,
   output logic [LANES-1:0][QW-1:0]     out_quot,
   output logic [SW-1:0]                out_side
);

   localparam int ST = (QW + 1) / 2;
   localparam int XW = (NW > DW + QW) ? NW : DW + QW;

   logic [ST-1:0]               valid_ff;
   logic [LANES-1:0][XW-1:0]    rem_ff  [ST];
   logic [LANES-1:0][DW-1:0]    den_ff  [ST];
   logic [LANES-1:0][QW-1:0]    quot_ff [ST];
   logic [SW-1:0]               side_ff [ST];

   for (genvar k = 0; k < ST; k++) begin : g_stage
      localparam int  I0  = QW - 1 - 2 * k;
      localparam int  I1  = (I0 > 0) ? I0 - 1 : 0;
      localparam bit  TWO = (I0 > 0);

      logic                       valid_d;
      logic [LANES-1:0][XW-1:0]   rem_d, rem_in;
      logic [LANES-1:0][DW-1:0]   den_d;
      logic [LANES-1:0][QW-1:0]   quot_d, quot_in;
      logic [SW-1:0]              side_d;

      if (k == 0) begin : g_first
         always_comb begin
            valid_d = in_valid;
            side_d  = in_side;
            den_d   = in_den;
            for (int l = 0; l < LANES; l++) begin
               rem_d[l]  = XW'(in_num[l]);
               quot_d[l] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            valid_d = valid_ff[k-1];
            side_d  = side_ff[k-1];
            den_d   = den_ff[k-1];
            rem_d   = rem_ff[k-1];
            quot_d  = quot_ff[k-1];
         end
      end

      always_comb begin
         logic [XW-1:0] r;
         logic [QW-1:0] q;
         logic [XW-1:0] dsh;
         for (int l = 0; l < LANES; l++) begin
            r   = rem_d[l];
            q   = quot_d[l];
            dsh = XW'(den_d[l]) << I0;
            if (r >= dsh) begin
               r     = r - dsh;
               q[I0] = 1'b1;
            end
            dsh = XW'(den_d[l]) << I1;
            if (TWO && (r >= dsh)) begin
               r     = r - dsh;
               q[I1] = 1'b1;
            end
            rem_in[l]  = r;
            quot_in[l] = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_d;
         end
         rem_ff[k]  <= rem_in;
         quot_ff[k] <= quot_in;
         den_ff[k]  <= den_d;
         side_ff[k] <= side_d;
      end
   end

   assign out_valid = valid_ff[ST-1];
   assign out_quot  = quot_ff[ST-1];
   assign out_side  = side_ff[ST-1];

endmodule

FILE: src/rgb_hsv_color_converter_unit.sv
// ---------------------------------------------------------------------------
// rgb_hsv_color_converter_unit
// Per-pixel RGB to HSV, HSV to RGB and saturation adjustment in fixed point.
// ---------------------------------------------------------------------------
// One pixel is taken every clock. Its result is registered on the rsp_out ports
// and sits there for one cycle with the rsp_valid strobe. busy is always low,
// as the receiver cannot stall and nothing backs up. The pipeline holds two
// pipelined dividers: an eight-stage one for hue and saturation, a four-stage
// one for the HSV to RGB channel rounding, plus six stages of arithmetic
// around them.
module rgb_hsv_color_converter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic [14:0] req_in_hue,
   input  logic [7:0]  req_in_sat,
   input  logic [7:0]  req_in_val,
   input  logic [11:0] req_sat_factor,
   output logic        rsp_valid,
   output logic [14:0] rsp_out_hue,
   output logic [7:0]  rsp_out_sat,
   output logic [7:0]  rsp_out_val,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue
);

   localparam int FSW = 54;
   localparam int BSW = 36;

   assign busy = 1'b0;

   // input stage
   logic        s1_valid_ff;
   logic [1:0]  s1_func_ff;
   logic [7:0]  s1_red_ff, s1_green_ff, s1_blue_ff, s1_sat_ff, s1_val_ff;
   logic [14:0] s1_hue_ff;
   logic [11:0] s1_fact_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_func_ff  <= req_func;
      s1_red_ff   <= req_in_red;
      s1_green_ff <= req_in_green;
      s1_blue_ff  <= req_in_blue;
      s1_hue_ff   <= req_in_hue;
      s1_sat_ff   <= req_in_sat;
      s1_val_ff   <= req_in_val;
      s1_fact_ff  <= req_sat_factor;
   end

   // max, min and hue sextant numerator
   logic [7:0]  mx, mn, delta;
   logic [10:0] hmul;

   always_comb begin
      mx = s1_red_ff;
      mn = s1_red_ff;
      if (s1_green_ff > mx) mx = s1_green_ff;
      if (s1_blue_ff > mx)  mx = s1_blue_ff;
      if (s1_green_ff < mn) mn = s1_green_ff;
      if (s1_blue_ff < mn)  mn = s1_blue_ff;
      delta = mx - mn;
      if (s1_red_ff == mx) begin
         if (s1_green_ff >= s1_blue_ff) begin
            hmul = 11'(s1_green_ff - s1_blue_ff);
         end else begin
            hmul = 11'(11'(delta) * 11'd6) - 11'(s1_blue_ff - s1_green_ff);
         end
      end else if (s1_green_ff == mx) begin
         hmul = 11'({delta, 1'b0}) + 11'(s1_blue_ff) - 11'(s1_red_ff);
      end else begin
         hmul = 11'({delta, 2'b00}) + 11'(s1_red_ff) - 11'(s1_green_ff);
      end
   end

   logic             s2_valid_ff;
   logic [1:0][23:0] s2_num_ff;
   logic [1:0][8:0]  s2_den_ff;
   logic [FSW-1:0]   s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_num_ff[0] <= 24'(hmul) * 24'(2 * rhc_pkg::HUE_SEXT) + 24'(delta);
      s2_den_ff[0] <= {delta, 1'b0};
      s2_num_ff[1] <= 24'(delta) * 24'(2 * rhc_pkg::CHAN_MAX) + 24'(mx);
      s2_den_ff[1] <= {mx, 1'b0};
      s2_side_ff   <= {s1_func_ff, s1_hue_ff, s1_sat_ff, s1_val_ff, s1_fact_ff, mx,
                       (delta == 8'd0)};
   end

   logic             fd_valid;
   logic [1:0][14:0] fd_quot;
   logic [FSW-1:0]   fd_side;

   rhc_div #(.LANES(2), .NW(24), .DW(9), .QW(15), .SW(FSW)) u_front_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid_ff),
      .in_num   (s2_num_ff),
      .in_den   (s2_den_ff),
      .in_side  (s2_side_ff),
      .out_valid(fd_valid),
      .out_quot (fd_quot),
      .out_side (fd_side)
   );

   // pick HSV source, scale saturation
   logic [1:0]  f_func;
   logic [14:0] f_hue;
   logic [7:0]  f_sat, f_val, f_mx;
   logic [11:0] f_fact;
   logic        f_zero;
   logic [14:0] h0;
   logic [7:0]  s0;
   logic [19:0] sprod;
   logic [11:0] sadj;
   logic [14:0] s3_h_in;
   logic [7:0]  s3_s_in, s3_v_in;

   always_comb begin
      {f_func, f_hue, f_sat, f_val, f_fact, f_mx, f_zero} = fd_side;
      h0    = f_zero ? 15'd0 : fd_quot[0];
      s0    = f_zero ? 8'd0 : fd_quot[1][7:0];
      sprod = 20'(s0) * 20'(f_fact) + 20'd128;
      sadj  = sprod[19:8];
      case (f_func)
         rhc_pkg::FUNC_HSV2RGB: begin
            s3_h_in = f_hue;
            s3_s_in = f_sat;
            s3_v_in = f_val;
         end
         rhc_pkg::FUNC_SAT_ADJ: begin
            s3_h_in = h0;
            s3_s_in = (sadj > 12'(rhc_pkg::CHAN_MAX)) ? 8'(rhc_pkg::CHAN_MAX) : sadj[7:0];
            s3_v_in = f_mx;
         end
         default: begin
            s3_h_in = h0;
            s3_s_in = s0;
            s3_v_in = f_mx;
         end
      endcase
   end

   logic        s3_valid_ff;
   logic [1:0]  s3_func_ff;
   logic [14:0] s3_h_ff;
   logic [7:0]  s3_s_ff, s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= fd_valid;
      end
      s3_func_ff <= f_func;
      s3_h_ff    <= s3_h_in;
      s3_s_ff    <= s3_s_in;
      s3_v_ff    <= s3_v_in;
   end

   // wrap hue, find sextant and distance to the edge in the middle of its sextant pair
   logic [14:0] hw, tb, tt;
   logic [2:0]  sext;
   logic [11:0] hdist;

   always_comb begin
      hw = (s3_h_ff >= 15'(rhc_pkg::HUE_FULL)) ? s3_h_ff - 15'(rhc_pkg::HUE_FULL) : s3_h_ff;
      sext = 3'(hw >= 15'(1 * rhc_pkg::HUE_SEXT)) + 3'(hw >= 15'(2 * rhc_pkg::HUE_SEXT))
           + 3'(hw >= 15'(3 * rhc_pkg::HUE_SEXT)) + 3'(hw >= 15'(4 * rhc_pkg::HUE_SEXT))
           + 3'(hw >= 15'(5 * rhc_pkg::HUE_SEXT));
      tb = 15'(sext[2:1]) * 15'(2 * rhc_pkg::HUE_SEXT);
      tt = hw - tb;
      if (tt >= 15'(rhc_pkg::HUE_SEXT)) begin
         hdist = 12'(tt - 15'(rhc_pkg::HUE_SEXT));
      end else begin
         hdist = 12'(15'(rhc_pkg::HUE_SEXT) - tt);
      end
   end

   logic        s4_valid_ff;
   logic [1:0]  s4_func_ff;
   logic [2:0]  s4_sext_ff;
   logic [11:0] s4_dist_ff;
   logic [15:0] s4_vs_ff, s4_va_ff;
   logic [7:0]  s4_v_ff, s4_s_ff;
   logic [14:0] s4_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_func_ff <= s3_func_ff;
      s4_sext_ff <= sext;
      s4_dist_ff <= hdist;
      s4_vs_ff   <= 16'(s3_v_ff) * 16'(s3_s_ff);
      s4_va_ff   <= 16'(s3_v_ff) * 16'(8'(rhc_pkg::CHAN_MAX) - s3_s_ff);
      s4_v_ff    <= s3_v_ff;
      s4_s_ff    <= s3_s_ff;
      s4_h_ff    <= s3_h_ff;
   end

   logic [27:0] xnum;

   assign xnum = 28'(s4_v_ff) * 28'(rhc_pkg::HSV_DEN) - 28'(s4_vs_ff) * 28'(s4_dist_ff);

   logic             s5_valid_ff;
   logic [1:0][28:0] s5_num_ff;
   logic [1:0][20:0] s5_den_ff;
   logic [BSW-1:0]   s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_num_ff[0] <= 29'({s4_va_ff, 1'b0}) + 29'(rhc_pkg::CHAN_MAX);
      s5_den_ff[0] <= 21'(2 * rhc_pkg::CHAN_MAX);
      s5_num_ff[1] <= 29'({xnum, 1'b0}) + 29'(rhc_pkg::HSV_DEN);
      s5_den_ff[1] <= 21'(2 * rhc_pkg::HSV_DEN);
      s5_side_ff   <= {s4_func_ff, s4_sext_ff, s4_v_ff, s4_h_ff, s4_s_ff};
   end

   logic             bd_valid;
   logic [1:0][7:0]  bd_quot;
   logic [BSW-1:0]   bd_side;

   rhc_div #(.LANES(2), .NW(29), .DW(21), .QW(8), .SW(BSW)) u_back_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s5_valid_ff),
      .in_num   (s5_num_ff),
      .in_den   (s5_den_ff),
      .in_side  (s5_side_ff),
      .out_valid(bd_valid),
      .out_quot (bd_quot),
      .out_side (bd_side)
   );

   // route channels by sextant, select by operation
   logic [1:0]  b_func;
   logic [2:0]  b_sext;
   logic [7:0]  b_v, b_s, zc, xc, cr, cg, cb;
   logic [14:0] b_h;
   logic [14:0] hue_in;
   logic [7:0]  sat_in, val_in, red_in, green_in, blue_in;

   always_comb begin
      {b_func, b_sext, b_v, b_h, b_s} = bd_side;
      zc = bd_quot[0];
      xc = bd_quot[1];
      case (b_sext)
         3'd0:    begin cr = b_v; cg = xc;  cb = zc;  end
         3'd1:    begin cr = xc;  cg = b_v; cb = zc;  end
         3'd2:    begin cr = zc;  cg = b_v; cb = xc;  end
         3'd3:    begin cr = zc;  cg = xc;  cb = b_v; end
         3'd4:    begin cr = xc;  cg = zc;  cb = b_v; end
         default: begin cr = b_v; cg = zc;  cb = xc;  end
      endcase
      hue_in   = '0;
      sat_in   = '0;
      val_in   = '0;
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      case (b_func)
         rhc_pkg::FUNC_RGB2HSV: begin
            hue_in = b_h;
            sat_in = b_s;
            val_in = b_v;
         end
         rhc_pkg::FUNC_HSV2RGB, rhc_pkg::FUNC_SAT_ADJ: begin
            red_in   = cr;
            green_in = cg;
            blue_in  = cb;
         end
         default: begin
            hue_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= bd_valid;
      end
      rsp_out_hue   <= hue_in;
      rsp_out_sat   <= sat_in;
      rsp_out_val   <= val_in;
      rsp_out_red   <= red_in;
      rsp_out_green <= green_in;
      rsp_out_blue  <= blue_in;
   end

endmodule

FILE: tb/rgb_hsv_color_converter_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_hsv_color_converter_unit_test
// Self-checking regression for the RGB/HSV colour converter. Pixels are sent
// in random bursts; a fixed-point colour model predicts each result and a
// checker compares every rsp_valid strobe against the oldest prediction.
// ---------------------------------------------------------------------------
module rgb_hsv_color_converter_unit_test;

   localparam int  LIMIT_CYCLES = 200000;
   localparam int  DRAIN_CYCLES = 40;
   localparam logic [rhc_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [rhc_pkg::HUE_W-1:0] hue;
      logic [rhc_pkg::CH_W-1:0]  sat;
      logic [rhc_pkg::CH_W-1:0]  val;
      logic [rhc_pkg::CH_W-1:0]  red;
      logic [rhc_pkg::CH_W-1:0]  green;
      logic [rhc_pkg::CH_W-1:0]  blue;
   } pixel_result_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_func;
   logic [7:0]        req_in_red, req_in_green, req_in_blue;
   logic [14:0]       req_in_hue;
   logic [7:0]        req_in_sat, req_in_val;
   logic [11:0]       req_sat_factor;
   logic              rsp_valid;
   logic [14:0]       rsp_out_hue;
   logic [7:0]        rsp_out_sat, rsp_out_val, rsp_out_red, rsp_out_green, rsp_out_blue;

   pixel_result_type  pending_pixels[$];
   int                error_count;
   int                cycle_count;
   int                burst_left;

   rgb_hsv_color_converter_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_in_red(req_in_red), .req_in_green(req_in_green),
      .req_in_blue(req_in_blue), .req_in_hue(req_in_hue), .req_in_sat(req_in_sat),
      .req_in_val(req_in_val), .req_sat_factor(req_sat_factor),
      .rsp_valid(rsp_valid), .rsp_out_hue(rsp_out_hue), .rsp_out_sat(rsp_out_sat),
      .rsp_out_val(rsp_out_val), .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green), .rsp_out_blue(rsp_out_blue)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------- colour model ----------------
   function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
      return (2 * n + d) / (2 * d);
   endfunction

   function automatic void rgb_to_hsv(input longint unsigned r, g, b,
                                      output longint unsigned h, s, v);
      longint unsigned mx, mn, delta;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      v = mx;
      h = 0; s = 0;
      if (delta != 0) begin
         s = round_div(delta * rhc_pkg::CHAN_MAX, mx);
         if (r == mx) begin
            if (g >= b) h = round_div((g - b) * rhc_pkg::HUE_SEXT, delta);
            else h = round_div(6 * rhc_pkg::HUE_SEXT * delta
                               - (b - g) * rhc_pkg::HUE_SEXT, delta);
         end else if (g == mx) begin
            h = round_div((2 * delta + b - r) * rhc_pkg::HUE_SEXT, delta);
         end else begin
            h = round_div((4 * delta + r - g) * rhc_pkg::HUE_SEXT, delta);
         end
      end
   endfunction

   function automatic void hsv_to_rgb(input longint unsigned h, s, v,
                                      output longint unsigned r, g, b);
      longint unsigned sext, t, hdist, base, zero, xc;
      h = h % rhc_pkg::HUE_FULL;
      sext = h / rhc_pkg::HUE_SEXT;
      t = h % (2 * rhc_pkg::HUE_SEXT);
      hdist = (t >= rhc_pkg::HUE_SEXT) ? t - rhc_pkg::HUE_SEXT : rhc_pkg::HUE_SEXT - t;
      base = v * rhc_pkg::HSV_DEN;
      zero = round_div(base - v * s * rhc_pkg::HUE_SEXT, rhc_pkg::HSV_DEN);
      xc = round_div(base - v * s * hdist, rhc_pkg::HSV_DEN);
      case (sext)
         0: begin r = v;    g = xc;   b = zero; end
         1: begin r = xc;   g = v;    b = zero; end
         2: begin r = zero; g = v;    b = xc;   end
         3: begin r = zero; g = xc;   b = v;    end
         4: begin r = xc;   g = zero; b = v;    end
         default: begin r = v; g = zero; b = xc; end
      endcase
   endfunction

   function automatic pixel_result_type predict_pixel();
      pixel_result_type res;
      longint unsigned  h, s, v, r, g, b;
      res = '0;
      if (req_func == rhc_pkg::FUNC_RGB2HSV) begin
         rgb_to_hsv(64'(req_in_red), 64'(req_in_green), 64'(req_in_blue), h, s, v);
         res.hue = h[14:0]; res.sat = s[7:0]; res.val = v[7:0];
      end else if (req_func == rhc_pkg::FUNC_HSV2RGB) begin
         hsv_to_rgb(64'(req_in_hue), 64'(req_in_sat), 64'(req_in_val), r, g, b);
         res.red = r[7:0]; res.green = g[7:0]; res.blue = b[7:0];
      end else if (req_func == rhc_pkg::FUNC_SAT_ADJ) begin
         rgb_to_hsv(64'(req_in_red), 64'(req_in_green), 64'(req_in_blue), h, s, v);
         s = round_div(s * 64'(req_sat_factor), 256);
         if (s > rhc_pkg::CHAN_MAX) s = rhc_pkg::CHAN_MAX;
         hsv_to_rgb(h, s, v, r, g, b);
         res.red = r[7:0]; res.green = g[7:0]; res.blue = b[7:0];
      end
      return res;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(input string what, input longint unsigned got, exp_v);
      error_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp_v);
   endtask

   always @(posedge clock) begin
      pixel_result_type exp_px;
      if (!reset) begin
         if (start && !busy) pending_pixels = {pending_pixels, predict_pixel()};
         if (rsp_valid) begin
            if (pending_pixels.size() == 0) begin
               error_count++;
               $display("unexpected result at %0t", $realtime);
            end else begin
               exp_px = pending_pixels.pop_front();
               if (rsp_out_hue !== exp_px.hue) report_mismatch("hue", rsp_out_hue, exp_px.hue);
               if (rsp_out_sat !== exp_px.sat) report_mismatch("sat", rsp_out_sat, exp_px.sat);
               if (rsp_out_val !== exp_px.val) report_mismatch("val", rsp_out_val, exp_px.val);
               if (rsp_out_red !== exp_px.red) report_mismatch("red", rsp_out_red, exp_px.red);
               if (rsp_out_green !== exp_px.green)
                  report_mismatch("green", rsp_out_green, exp_px.green);
               if (rsp_out_blue !== exp_px.blue)
                  report_mismatch("blue", rsp_out_blue, exp_px.blue);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("rgb_hsv_color_converter_unit regression: fail");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   // Drive on the falling edge; hold start until the transfer, then gap at
   // the end of a random burst.
   task automatic send_pixel(input logic [1:0] func, input logic [7:0] r, g, b,
                             input logic [14:0] h, input logic [7:0] s, v,
                             input logic [11:0] factor);
      int gap;
      @(negedge clock);
      req_func = func; req_in_red = r; req_in_green = g; req_in_blue = b;
      req_in_hue = h; req_in_sat = s; req_in_val = v; req_sat_factor = factor;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         start = 1'b0;
         req_func = 2'($urandom); req_in_red = 8'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [14:0] rand_hue();
      case ($urandom_range(0, 9))
         0: return 15'(rhc_pkg::HUE_SEXT * $urandom_range(0, 6));
         1: return 15'($urandom_range(rhc_pkg::HUE_FULL, 32767));
         default: return 15'($urandom_range(0, rhc_pkg::HUE_FULL - 1));
      endcase
   endfunction

   function automatic logic [11:0] rand_factor();
      case ($urandom_range(0, 7))
         0: return 12'd256;
         1: return 12'd0;
         2: return 12'd4095;
         3: return 12'($urandom_range(0, 511));
         default: return 12'($urandom);
      endcase
   endfunction

   // Random RGB pixel, with ties between channels made common.
   task automatic send_rgb(input logic [1:0] func);
      logic [7:0] r, g, b;
      r = rand_chan(); g = rand_chan(); b = rand_chan();
      case ($urandom_range(0, 7))
         0: g = r;
         1: b = r;
         2: b = g;
         3: begin g = r; b = r; end
         default: ;
      endcase
      send_pixel(func, r, g, b, 15'($urandom), 8'($urandom), 8'($urandom), rand_factor());
   endtask

   task automatic test_directed();
      send_pixel(rhc_pkg::FUNC_RGB2HSV, 8'd0, 8'd0, 8'd0, 15'd0, 8'd0, 8'd0, 12'd0);
      send_pixel(rhc_pkg::FUNC_RGB2HSV, 8'd255, 8'd255, 8'd255, 15'h7fff, 8'hff, 8'hff,
                 12'hfff);
      send_pixel(rhc_pkg::FUNC_RGB2HSV, 8'd255, 8'd0, 8'd0, 15'd0, 8'd0, 8'd0, 12'd0);
      send_pixel(rhc_pkg::FUNC_RGB2HSV, 8'd255, 8'd0, 8'd1, 15'd0, 8'd0, 8'd0, 12'd0);
      send_pixel(rhc_pkg::FUNC_RGB2HSV, 8'd255, 8'd255, 8'd0, 15'd0, 8'd0, 8'd0, 12'd0);
      send_pixel(rhc_pkg::FUNC_RGB2HSV, 8'd0, 8'd255, 8'd255, 15'd0, 8'd0, 8'd0, 12'd0);
      send_pixel(rhc_pkg::FUNC_RGB2HSV, 8'd10, 8'd20, 8'd200, 15'd0, 8'd0, 8'd0, 12'd0);
      send_pixel(rhc_pkg::FUNC_HSV2RGB, 8'd0, 8'd0, 8'd0, 15'd0, 8'd255, 8'd255, 12'd0);
      send_pixel(rhc_pkg::FUNC_HSV2RGB, 8'd0, 8'd0, 8'd0, 15'(rhc_pkg::HUE_FULL),
                 8'd255, 8'd255, 12'd0);
      send_pixel(rhc_pkg::FUNC_HSV2RGB, 8'd0, 8'd0, 8'd0, 15'h7fff, 8'd128, 8'd200, 12'd0);
      send_pixel(rhc_pkg::FUNC_HSV2RGB, 8'd0, 8'd0, 8'd0, 15'(rhc_pkg::HUE_FULL - 1),
                 8'd255, 8'd255, 12'd0);
      send_pixel(rhc_pkg::FUNC_HSV2RGB, 8'd0, 8'd0, 8'd0, 15'(3 * rhc_pkg::HUE_SEXT),
                 8'd0, 8'd77, 12'd0);
      send_pixel(rhc_pkg::FUNC_HSV2RGB, 8'd0, 8'd0, 8'd0, 15'(5 * rhc_pkg::HUE_SEXT + 7),
                 8'd255, 8'd0, 12'd0);
      send_pixel(rhc_pkg::FUNC_SAT_ADJ, 8'd200, 8'd100, 8'd50, 15'd0, 8'd0, 8'd0, 12'd256);
      send_pixel(rhc_pkg::FUNC_SAT_ADJ, 8'd200, 8'd100, 8'd50, 15'd0, 8'd0, 8'd0, 12'd0);
      send_pixel(rhc_pkg::FUNC_SAT_ADJ, 8'd200, 8'd100, 8'd50, 15'd0, 8'd0, 8'd0, 12'hfff);
      send_pixel(rhc_pkg::FUNC_SAT_ADJ, 8'd255, 8'd0, 8'd1, 15'd0, 8'd0, 8'd0, 12'd300);
      send_pixel(rhc_pkg::FUNC_SAT_ADJ, 8'd90, 8'd90, 8'd90, 15'd0, 8'd0, 8'd0, 12'hfff);
      send_pixel(FUNC_UNUSED, 8'd255, 8'd255, 8'd255, 15'h7fff, 8'hff, 8'hff, 12'hfff);
   endtask

   task automatic test_rgb_to_hsv();
      repeat (300) send_rgb(rhc_pkg::FUNC_RGB2HSV);
   endtask

   task automatic test_hsv_to_rgb();
      repeat (300)
         send_pixel(rhc_pkg::FUNC_HSV2RGB, 8'($urandom), 8'($urandom), 8'($urandom),
                    rand_hue(), rand_chan(), rand_chan(), 12'($urandom));
   endtask

   task automatic test_saturation_adjust();
      repeat (300) send_rgb(rhc_pkg::FUNC_SAT_ADJ);
   endtask

   task automatic test_mixed_stream();
      logic [1:0] func;
      repeat (330) begin
         func = ($urandom_range(0, 19) == 0) ? FUNC_UNUSED : 2'($urandom_range(0, 2));
         if (func == rhc_pkg::FUNC_HSV2RGB)
            send_pixel(func, 8'($urandom), 8'($urandom), 8'($urandom), rand_hue(),
                       rand_chan(), rand_chan(), 12'($urandom));
         else
            send_rgb(func);
      end
   endtask

   initial begin
      error_count = 0; cycle_count = 0; burst_left = 0;
      reset = 1'b1; start = 1'b0;
      req_func = '0; req_in_red = '0; req_in_green = '0; req_in_blue = '0;
      req_in_hue = '0; req_in_sat = '0; req_in_val = '0; req_sat_factor = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_rgb_to_hsv();
      test_hsv_to_rgb();
      test_saturation_adjust();
      test_mixed_stream();
      @(negedge clock);
      start = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("rgb_hsv_color_converter_unit regression: pass");
      else
         $display("rgb_hsv_color_converter_unit regression: fail");
      $finish;
   end

endmodule
